// ----- rtl/lfu_pkg.sv -----
// Shared constants, codes and types of the LFU cache with LRU tie break.
`default_nettype none

package lfu_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned COUNT_W_DEF = 16;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_SEL_BIT = 2;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPD_END,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/lfu_if.sv -----
// Request and response stream interfaces of the LFU cache.
`default_nettype none

interface lfu_req_if import lfu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [KEY_W-1:0] req_key;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, req_type, req_key, write_value, input ready);
  modport sink (input valid, req_type, req_key, write_value, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink (input valid, found, read_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfu_store.sv -----
// Entry memory with one read and one write port, plus per-entry valid flags.
`default_nettype none

module lfu_store import lfu_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned REC_W   = 80,
  parameter int unsigned IDX_W   = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [REC_W-1:0] wr_data_i,
  output logic [REC_W-1:0] rd_data_o,
  output logic             rd_valid_o,
  output logic             rd_vld_o,
  output logic [IDX_W-1:0] rd_idx_o
);

  logic [REC_W-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic               rd_vld_q;
  logic               rd_valid_q;
  logic [REC_W-1:0]   rd_data_q;
  logic [IDX_W-1:0]   rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
      rd_idx_q  <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en && ctrl_i.set_valid) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= ctrl_i.rd_en;
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;
  assign rd_vld_o   = rd_vld_q;
  assign rd_idx_o   = rd_idx_q;

endmodule

`default_nettype wire

// ----- rtl/lfu_scan.sv -----
// Per-entry compare unit: key match, free slot, victim choice and rank bump.
`default_nettype none

module lfu_scan import lfu_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  logic                   scan_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic                   ent_valid_i,
  input  logic [KEY_W-1:0]       ent_key_i,
  input  logic [VAL_W-1:0]       ent_value_i,
  input  logic [COUNT_WIDTH-1:0] ent_count_i,
  input  logic [IDX_W-1:0]       ent_rank_i,
  input  logic [KEY_W-1:0]       key_i,
  input  logic [IDX_W-1:0]       tgt_idx_i,
  input  logic [IDX_W-1:0]       limit_i,
  input  logic                   limit_all_i,
  output logic                   bump_o,
  output logic                   hit_o,
  output logic [IDX_W-1:0]       hit_idx_o,
  output logic [VAL_W-1:0]       hit_value_o,
  output logic [COUNT_WIDTH-1:0] hit_count_o,
  output logic [IDX_W-1:0]       hit_rank_o,
  output logic                   free_o,
  output logic [IDX_W-1:0]       free_idx_o,
  output logic                   vic_o,
  output logic [IDX_W-1:0]       vic_idx_o,
  output logic [IDX_W-1:0]       vic_rank_o
);

  logic                   hit_q, free_q, vic_q;
  logic [IDX_W-1:0]       hit_idx_q, hit_rank_q, free_idx_q, vic_idx_q, vic_rank_q;
  logic [VAL_W-1:0]       hit_value_q;
  logic [COUNT_WIDTH-1:0] hit_count_q, vic_count_q;
  logic                   take_hit, take_free, take_vic;

  always_comb begin
    take_hit  = scan_i && ent_valid_i && (ent_key_i == key_i) && !hit_q;
    take_free = scan_i && !ent_valid_i && !free_q;
    // lower count wins; on equal count the older (higher rank) wins
    take_vic  = scan_i && ent_valid_i &&
                (!vic_q || (ent_count_i < vic_count_q) ||
                 ((ent_count_i == vic_count_q) && (ent_rank_i > vic_rank_q)));
    bump_o    = ent_valid_i && (idx_i != tgt_idx_i) &&
                (limit_all_i || (ent_rank_i < limit_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      vic_q  <= 1'b0;
    end else if (clear_i) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      vic_q  <= 1'b0;
    end else begin
      if (take_hit) begin
        hit_q <= 1'b1;
      end
      if (take_free) begin
        free_q <= 1'b1;
      end
      if (take_vic) begin
        vic_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q   <= idx_i;
      hit_value_q <= ent_value_i;
      hit_count_q <= ent_count_i;
      hit_rank_q  <= ent_rank_i;
    end
    if (take_free) begin
      free_idx_q <= idx_i;
    end
    if (take_vic) begin
      vic_idx_q   <= idx_i;
      vic_count_q <= ent_count_i;
      vic_rank_q  <= ent_rank_i;
    end
  end

  assign hit_o       = hit_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_value_o = hit_value_q;
  assign hit_count_o = hit_count_q;
  assign hit_rank_o  = hit_rank_q;
  assign free_o      = free_q;
  assign free_idx_o  = free_idx_q;
  assign vic_o       = vic_q;
  assign vic_idx_o   = vic_idx_q;
  assign vic_rank_o  = vic_rank_q;

endmodule

`default_nettype wire

// ----- rtl/lfu_cache_lru_tiebreak.sv -----
// LFU key/value cache with LRU tie break: top level, sequencer and register port.
// Requests arrive on req_i (get or set of a 32-bit key); each get returns one
// word on rsp_o (found flag and value, all ones on a miss); a set returns none.
// Every request walks the entry memory once, one entry per cycle, to find the
// key, the first free slot and the eviction victim. A request that changes
// recency then walks the memory again to age the ranks, and ends with one
// write of the touched or new entry. The single memory read port sets the pace;
// the block takes one request at a time. A get's word is loaded into the output
// register in the decide state, after the lookup walk. req_i is ready only while
// the block is idle; a waiting response word does not hold it off, but a
// following get waits for the output register to drain before it can finish.
// At reset all entries are invalid, occupancy is zero and capacity_in_use is 16.
// The capacity register sits at byte address 0 of the APB port; it is to be
// written only while the block idles, and the block itself does not enforce it.
`default_nettype none

module lfu_cache_lru_tiebreak import lfu_pkg::*; #(
  parameter int unsigned ENTRIES     = ENTRIES_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lfu_req_if.sink               req_i,
  lfu_rsp_if.source             rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int unsigned REC_W = KEY_W + VAL_W + COUNT_WIDTH + IDX_W;
  localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CMP_W-1:0]       ENT_CMP  = CMP_W'(ENTRIES);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [VAL_W-1:0]       value;
    logic [COUNT_WIDTH-1:0] count;
    logic [IDX_W-1:0]       rank;
  } entry_t;

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       addr_q, addr_d;
  logic                   type_q;
  logic [KEY_W-1:0]       key_q;
  logic [VAL_W-1:0]       wval_q;
  logic [CAP_W-1:0]       cap_q;
  logic [OCC_W-1:0]       occ_q;
  logic                   out_valid_q, out_valid_d;
  logic                   out_found_q;
  logic [VAL_W-1:0]       out_value_q;
  logic [IDX_W-1:0]       tgt_q, tgt_d;
  logic [IDX_W-1:0]       limit_q, limit_d;
  logic                   all_q, all_d;
  logic [VAL_W-1:0]       new_value_q, new_value_d;
  logic [COUNT_WIDTH-1:0] new_count_q, new_count_d;
  logic                   set_valid_q, set_valid_d;
  logic                   dec_go;

  mem_ctrl_t              mem_ctrl;
  logic [IDX_W-1:0]       wr_addr;
  logic [REC_W-1:0]       wr_data;
  logic [REC_W-1:0]       rd_data;
  logic                   rd_valid, rd_vld;
  logic [IDX_W-1:0]       rd_idx;
  entry_t                 rd_ent, upd_ent, new_ent;

  logic                   accept, clear, scan, bump, load_out, out_busy, cfg_we;
  logic [CMP_W-1:0]       cap_ext, cap_eff, occ_ext;

  logic                   hit, free, vic;
  logic [IDX_W-1:0]       hit_idx, hit_rank, free_idx, vic_idx, vic_rank;
  logic [VAL_W-1:0]       hit_value;
  logic [COUNT_WIDTH-1:0] hit_count, hit_count_inc;

  lfu_store #(
    .ENTRIES (ENTRIES),
    .REC_W   (REC_W),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mem_ctrl),
    .rd_addr_i  (addr_q),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid),
    .rd_vld_o   (rd_vld),
    .rd_idx_o   (rd_idx)
  );

  assign rd_ent = entry_t'(rd_data);

  lfu_scan #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .scan_i      (scan),
    .idx_i       (rd_idx),
    .ent_valid_i (rd_valid),
    .ent_key_i   (rd_ent.key),
    .ent_value_i (rd_ent.value),
    .ent_count_i (rd_ent.count),
    .ent_rank_i  (rd_ent.rank),
    .key_i       (key_q),
    .tgt_idx_i   (tgt_q),
    .limit_i     (limit_q),
    .limit_all_i (all_q),
    .bump_o      (bump),
    .hit_o       (hit),
    .hit_idx_o   (hit_idx),
    .hit_value_o (hit_value),
    .hit_count_o (hit_count),
    .hit_rank_o  (hit_rank),
    .free_o      (free),
    .free_idx_o  (free_idx),
    .vic_o       (vic),
    .vic_idx_o   (vic_idx),
    .vic_rank_o  (vic_rank)
  );

  // configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[REG_SEL_BIT] == REG_CAPACITY);

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_CAPACITY: prdata = APB_DATA_W'(cap_q);
      default:      prdata = '0;
    endcase
  end

  // decision after the lookup walk
  always_comb begin
    cap_ext       = CMP_W'(cap_q);
    cap_eff       = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;
    occ_ext       = CMP_W'(occ_q);
    hit_count_inc = (hit_count == CNT_MAX) ? hit_count : hit_count + CNT_ONE;

    dec_go      = 1'b0;
    tgt_d       = hit_idx;
    limit_d     = hit_rank;
    all_d       = 1'b0;
    new_value_d = hit_value;
    new_count_d = hit_count_inc;
    set_valid_d = 1'b0;

    if (hit) begin
      dec_go = 1'b1;
      if (type_q == REQ_SET) begin
        new_value_d = wval_q;
      end
    end else if ((type_q == REQ_SET) && (cap_eff != '0)) begin
      new_value_d = wval_q;
      new_count_d = CNT_ONE;
      if (occ_ext < cap_eff) begin
        // new entry: every valid entry ages by one
        dec_go      = free;
        tgt_d       = free_idx;
        all_d       = 1'b1;
        set_valid_d = 1'b1;
      end else begin
        dec_go  = vic;
        tgt_d   = vic_idx;
        limit_d = vic_rank;
      end
    end
  end

  // sequencer
  assign out_busy = out_valid_q && !rsp_o.ready;

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    accept        = 1'b0;
    clear         = 1'b0;
    load_out      = 1'b0;
    mem_ctrl      = '0;
    req_i.ready   = 1'b0;
    scan          = rd_vld && ((state_q == ST_SCAN) || (state_q == ST_SCAN_END));
    wr_addr       = rd_idx;
    upd_ent       = rd_ent;
    upd_ent.rank  = rd_ent.rank + IDX_W'(1);
    new_ent.key   = key_q;
    new_ent.value = new_value_q;
    new_ent.count = new_count_q;
    new_ent.rank  = '0;
    wr_data       = REC_W'(upd_ent);

    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          accept  = 1'b1;
          clear   = 1'b1;
          addr_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        mem_ctrl.rd_en = 1'b1;
        addr_d         = addr_q + IDX_W'(1);
        if (addr_q == LAST_IDX) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // hold a get until the output register can take its word
        if (!((type_q == REQ_GET) && out_busy)) begin
          load_out = (type_q == REQ_GET);
          addr_d   = '0;
          state_d  = dec_go ? ST_UPDATE : ST_IDLE;
        end
      end
      ST_UPDATE: begin
        mem_ctrl.rd_en = 1'b1;
        mem_ctrl.wr_en = rd_vld && bump;
        addr_d         = addr_q + IDX_W'(1);
        if (addr_q == LAST_IDX) begin
          state_d = ST_UPD_END;
        end
      end
      ST_UPD_END: begin
        mem_ctrl.wr_en = rd_vld && bump;
        state_d        = ST_COMMIT;
      end
      ST_COMMIT: begin
        mem_ctrl.wr_en     = 1'b1;
        mem_ctrl.set_valid = set_valid_q;
        wr_addr            = tgt_q;
        wr_data            = REC_W'(new_ent);
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        cap_q <= pwdata[CAP_W-1:0];
      end
      if ((state_q == ST_COMMIT) && set_valid_q) begin
        occ_q <= occ_q + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q <= req_i.req_type;
      key_q  <= req_i.req_key;
      wval_q <= req_i.write_value;
    end
    if (load_out) begin
      out_found_q <= hit;
      out_value_q <= hit ? hit_value : MISS_VALUE;
    end
    if (state_q == ST_DECIDE) begin
      tgt_q       <= tgt_d;
      limit_q     <= limit_d;
      all_q       <= all_d;
      new_value_q <= new_value_d;
      new_count_q <= new_count_d;
      set_valid_q <= set_valid_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.read_value = out_value_q;

endmodule

`default_nettype wire
